FILE: sv/lattice_gas_exchange_step_core_assert.svh
`ifndef LATTICE_GAS_EXCHANGE_STEP_CORE_ASSERT_SVH
`define LATTICE_GAS_EXCHANGE_STEP_CORE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define LGX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lgx check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define LGX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lgx check failed");

`endif

FILE: sv/lgx_pkg.sv
`default_nettype none

package lgx_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int NR_W   = $clog2(MAX_ROWS + 1);
    localparam int NC_W   = $clog2(MAX_COLS + 1);
    localparam int NRX_W  = NR_W + 1;
    localparam int NCX_W  = NC_W + 1;

    localparam int CMD_W        = 2;
    localparam int ROW_FIELD_W  = 6;
    localparam int COL_FIELD_W  = 6;
    localparam int DIR_W        = 2;
    localparam int CHANCE_W     = 16;
    localparam int COUNT_W      = 16;
    localparam int WEIGHT_W     = 16;
    localparam int PROD_W       = 32;
    localparam int CHANCE_SHIFT = 11;
    localparam int SIZE_W       = 7;
    localparam int FIELD_CFG_W  = 48;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int READ_SLOTS   = 4;
    localparam int SLOT_CNT_W   = 2;
    localparam int SUM_W        = 3;
    localparam int IDX_W        = 4;

    localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_TOP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD   = 3'd5;

    localparam logic [SIZE_W-1:0]      RST_ROWS    = 7'd64;
    localparam logic [SIZE_W-1:0]      RST_COLS    = 7'd64;
    localparam logic [CFG_DATA_W-1:0]  RST_CW_LOW  = 64'd32768;
    localparam logic [CFG_DATA_W-1:0]  RST_CW_HIGH = 64'd0;
    localparam logic [WEIGHT_W-1:0]    RST_CW_TOP  = 16'd0;
    localparam logic [FIELD_CFG_W-1:0] RST_FIELD   = 48'h1000_1000_1000;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        logic [DIR_W-1:0]       direction;
        logic [CHANCE_W-1:0]    chance;
        logic                   write_value;
    } t_item;

    typedef struct packed {
        logic               site_value;
        logic               swapped;
        logic [COUNT_W-1:0] down_count;
        logic [COUNT_W-1:0] up_count;
        logic               out_of_range;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic sum;
        logic mul;
        logic commit;
        logic write2;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic short_cmd;
        logic second;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/lgx_ctrl.sv
`default_nettype none

module lgx_ctrl import lgx_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_stat i_stat,
    output t_ctl       o_ctl,
    output logic       busy,
    output logic       o_done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;
    localparam logic [2:0] S_WRITE2 = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [SLOT_CNT_W-1:0] r_cnt;
    logic [SLOT_CNT_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_stat.short_cmd ? S_COMMIT : S_READ;
                end
            end
            S_READ: begin
                o_ctl.issue = 1'b1;
                n_cnt       = r_cnt + SLOT_CNT_W'(1);
                if (r_cnt == SLOT_CNT_W'(READ_SLOTS - 1)) begin
                    n_state = S_WAIT;
                end
            end
            // last row lands in the row window
            S_WAIT: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                o_ctl.sum = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = S_COMMIT;
            end
            S_COMMIT: begin
                o_ctl.commit = 1'b1;
                n_state      = i_stat.second ? S_WRITE2 : S_DONE;
            end
            S_WRITE2: begin
                o_ctl.write2 = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

`default_nettype wire

FILE: sv/lgx_datapath.sv
`default_nettype none

module lgx_datapath import lgx_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_item                 i_item,
    input  wire t_ctl                  i_ctl,
    output t_stat                      o_stat,
    output t_result                    o_result
);

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] x,
                                                 input logic [NR_W-1:0] n);
        logic [NRX_W-1:0] xp;
        xp = NRX_W'(x) + NRX_W'(1);
        return (xp >= NRX_W'(n)) ? '0 : xp[ROW_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] row_dec(input logic [ROW_W-1:0] x,
                                                 input logic [NR_W-1:0] n);
        return (x == '0) ? ROW_W'(n - NR_W'(1)) : x - ROW_W'(1);
    endfunction

    function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] x,
                                                 input logic [NC_W-1:0] n);
        logic [NCX_W-1:0] xp;
        xp = NCX_W'(x) + NCX_W'(1);
        return (xp >= NCX_W'(n)) ? '0 : xp[COL_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] col_dec(input logic [COL_W-1:0] x,
                                                 input logic [NC_W-1:0] n);
        return (x == '0) ? COL_W'(n - NC_W'(1)) : x - COL_W'(1);
    endfunction

    // configuration
    logic [SIZE_W-1:0]      r_rows_cfg;
    logic [SIZE_W-1:0]      r_cols_cfg;
    logic [CFG_DATA_W-1:0]  r_cw_low;
    logic [CFG_DATA_W-1:0]  r_cw_high;
    logic [WEIGHT_W-1:0]    r_cw_top;
    logic [FIELD_CFG_W-1:0] r_fw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= RST_ROWS;
            r_cols_cfg <= RST_COLS;
            r_cw_low   <= RST_CW_LOW;
            r_cw_high  <= RST_CW_HIGH;
            r_cw_top   <= RST_CW_TOP;
            r_fw       <= RST_FIELD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS:    r_rows_cfg <= i_cfg_data[SIZE_W-1:0];
                CFG_COLS:    r_cols_cfg <= i_cfg_data[SIZE_W-1:0];
                CFG_CW_LOW:  r_cw_low   <= i_cfg_data;
                CFG_CW_HIGH: r_cw_high  <= i_cfg_data;
                CFG_CW_TOP:  r_cw_top   <= i_cfg_data[WEIGHT_W-1:0];
                CFG_FIELD:   r_fw       <= i_cfg_data[FIELD_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sizes in use: zero acts as one, too large clamps to the bound
    logic [NR_W-1:0] nr;
    logic [NC_W-1:0] nc;

    always_comb begin
        if (r_rows_cfg == '0) begin
            nr = NR_W'(1);
        end else if (int'(r_rows_cfg) > MAX_ROWS) begin
            nr = NR_W'(MAX_ROWS);
        end else begin
            nr = NR_W'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            nc = NC_W'(1);
        end else if (int'(r_cols_cfg) > MAX_COLS) begin
            nc = NC_W'(MAX_COLS);
        end else begin
            nc = NC_W'(r_cols_cfg);
        end
    end

    // command capture
    logic             oor_in;
    logic [ROW_W-1:0] row_in;
    logic [ROW_W-1:0] row_m1;
    logic [ROW_W-1:0] row_m2;

    assign oor_in = (i_item.cmd != CMD_CLEAR)
                 && ((int'(i_item.row) >= int'(nr)) || (int'(i_item.col) >= int'(nc)));
    assign row_in = ROW_W'(i_item.row);
    assign row_m1 = row_dec(row_in, nr);
    assign row_m2 = row_dec(row_m1, nr);

    assign o_stat.short_cmd = (i_item.cmd == CMD_CLEAR) || oor_in;

    logic [CMD_W-1:0]    r_cmd;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [DIR_W-1:0]    r_dir;
    logic [CHANCE_W-1:0] r_chance;
    logic                r_wval;
    logic                r_oor;
    logic                r_site_hi;
    logic                r_par_hi;
    logic                r_vert;
    logic [ROW_W-1:0]    r_addr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= i_item.cmd;
            r_row     <= row_in;
            r_col     <= COL_W'(i_item.col);
            r_dir     <= i_item.direction;
            r_chance  <= i_item.chance;
            r_wval    <= i_item.write_value;
            r_oor     <= oor_in;
            // window of four rows starts one above the site, two for an up move
            r_site_hi <= (i_item.cmd == CMD_MOVE) && (i_item.direction == DIR_UP);
            r_par_hi  <= (i_item.cmd == CMD_MOVE) && (i_item.direction == DIR_DOWN);
            r_vert    <= (i_item.cmd == CMD_MOVE)
                      && ((i_item.direction == DIR_DOWN) || (i_item.direction == DIR_UP));
            r_addr    <= ((i_item.cmd == CMD_MOVE) && (i_item.direction == DIR_UP))
                       ? row_m2 : row_m1;
        end else if (i_ctl.issue) begin
            r_addr <= row_inc(r_addr, nr);
        end
    end

    // lattice rows, a row never written reads as empty
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_row_valid;
    logic [MAX_COLS-1:0] r_rd_data;
    logic                r_rd_ok;
    logic                r_cap;
    logic [MAX_COLS-1:0] rd_row;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_rd_data <= mem[r_addr];
        end
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_cap       <= 1'b0;
        end else begin
            r_cap <= i_ctl.issue;
            if (mem_we) begin
                r_row_valid[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_rd_ok <= r_row_valid[r_addr];
        end
    end

    assign rd_row = r_rd_ok ? r_rd_data : '0;

    // four-row window, filled oldest first
    logic [MAX_COLS-1:0] r_rows [READ_SLOTS];

    always_ff @(posedge i_clk) begin
        if (r_cap) begin
            for (int k = 0; k < READ_SLOTS - 1; k++) begin
                r_rows[k] <= r_rows[k+1];
            end
            r_rows[READ_SLOTS-1] <= rd_row;
        end
    end

    // local neighborhood of the site and its partner
    logic [MAX_COLS-1:0] site_row;
    logic [MAX_COLS-1:0] site_up;
    logic [MAX_COLS-1:0] site_dn;
    logic [MAX_COLS-1:0] par_row;
    logic [MAX_COLS-1:0] par_up;
    logic [MAX_COLS-1:0] par_dn;
    logic [COL_W-1:0]    c_dec;
    logic [COL_W-1:0]    c_inc;
    logic [COL_W-1:0]    pc;
    logic [COL_W-1:0]    pc_dec;
    logic [COL_W-1:0]    pc_inc;
    logic                a_bit;
    logic                b_bit;
    logic [SUM_W-1:0]    sum_a;
    logic [SUM_W-1:0]    sum_b;
    logic [IDX_W-1:0]    idx;

    always_comb begin
        site_row = r_site_hi ? r_rows[2] : r_rows[1];
        site_up  = r_site_hi ? r_rows[1] : r_rows[0];
        site_dn  = r_site_hi ? r_rows[3] : r_rows[2];
        par_row  = r_par_hi  ? r_rows[2] : site_row;
        par_up   = r_par_hi  ? r_rows[1] : site_up;
        par_dn   = r_par_hi  ? r_rows[3] : site_dn;
        if (r_site_hi) begin
            par_row = r_rows[1];
            par_up  = r_rows[0];
            par_dn  = r_rows[2];
        end
    end

    always_comb begin
        c_dec = col_dec(r_col, nc);
        c_inc = col_inc(r_col, nc);
        case (r_dir)
            DIR_LEFT:  pc = c_dec;
            DIR_RIGHT: pc = c_inc;
            default:   pc = r_col;
        endcase
        if (r_cmd != CMD_MOVE) begin
            pc = r_col;
        end
        pc_dec = col_dec(pc, nc);
        pc_inc = col_inc(pc, nc);
        a_bit  = site_row[r_col];
        b_bit  = par_row[pc];
        sum_a  = SUM_W'(site_up[r_col]) + SUM_W'(site_dn[r_col])
               + SUM_W'(site_row[c_inc]) + SUM_W'(site_row[c_dec]);
        sum_b  = SUM_W'(par_up[pc]) + SUM_W'(par_dn[pc])
               + SUM_W'(par_row[pc_inc]) + SUM_W'(par_row[pc_dec]);
        idx    = (a_bit ? IDX_W'(sum_a) : '0) + (b_bit ? IDX_W'(sum_b) : '0);
    end

    logic             r_a;
    logic             r_b;
    logic [IDX_W-1:0] r_idx;
    logic [COL_W-1:0] r_pc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            r_a   <= a_bit;
            r_b   <= b_bit;
            r_idx <= idx;
            r_pc  <= pc;
        end
    end

    // weight product, UQ1.15 times UQ4.12
    logic [WEIGHT_W-1:0] cw;
    logic [WEIGHT_W-1:0] fw;
    logic [PROD_W-1:0]   r_prod;

    always_comb begin
        if (r_idx < IDX_W'(4)) begin
            cw = r_cw_low[{r_idx[1:0], 4'b0000} +: WEIGHT_W];
        end else if (r_idx < IDX_W'(8)) begin
            cw = r_cw_high[{r_idx[1:0], 4'b0000} +: WEIGHT_W];
        end else begin
            cw = r_cw_top;
        end
        case (r_dir)
            DIR_DOWN: fw = r_fw[2*WEIGHT_W +: WEIGHT_W];
            DIR_UP:   fw = r_fw[0 +: WEIGHT_W];
            default:  fw = r_fw[WEIGHT_W +: WEIGHT_W];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(cw) * PROD_W'(fw);
        end
    end

    // commit: decision, row write back, counters, result
    logic                do_move;
    logic                do_swap;
    logic [MAX_COLS-1:0] site_new;
    logic [MAX_COLS-1:0] par_new;
    logic [MAX_COLS-1:0] wr_new;
    logic [ROW_W-1:0]    par_addr;
    logic [COUNT_W-1:0]  r_down;
    logic [COUNT_W-1:0]  r_up;
    logic [COUNT_W-1:0]  n_down;
    logic [COUNT_W-1:0]  n_up;
    t_result             r_res;

    always_comb begin
        do_move = (r_cmd == CMD_MOVE) && !r_oor && (r_a != r_b);
        do_swap = do_move && (r_prod >= (PROD_W'(r_chance) << CHANCE_SHIFT));

        site_new        = site_row;
        site_new[r_col] = r_b;
        if (!r_vert) begin
            site_new[r_pc] = r_a;
        end
        par_new        = par_row;
        par_new[r_col] = r_a;
        wr_new         = r_rows[1];
        wr_new[r_col]  = r_wval;
        par_addr       = r_par_hi ? row_inc(r_row, nr) : row_dec(r_row, nr);

        mem_we    = 1'b0;
        mem_waddr = r_row;
        mem_wdata = site_new;
        if (i_ctl.commit) begin
            if ((r_cmd == CMD_WRITE) && !r_oor) begin
                mem_we    = 1'b1;
                mem_wdata = wr_new;
            end else if (do_swap) begin
                mem_we = 1'b1;
            end
        end else if (i_ctl.write2) begin
            mem_we    = 1'b1;
            mem_waddr = par_addr;
            mem_wdata = par_new;
        end

        n_down = r_down;
        n_up   = r_up;
        if (r_cmd == CMD_CLEAR) begin
            n_down = '0;
            n_up   = '0;
        end else if (do_swap) begin
            if ((r_dir == DIR_DOWN) && (r_down != '1)) begin
                n_down = r_down + COUNT_W'(1);
            end else if ((r_dir == DIR_UP) && (r_up != '1)) begin
                n_up = r_up + COUNT_W'(1);
            end
        end
    end

    assign o_stat.second = do_swap && r_vert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down <= '0;
            r_up   <= '0;
        end else if (i_ctl.commit) begin
            r_down <= n_down;
            r_up   <= n_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_res.swapped      <= do_swap;
            r_res.down_count   <= n_down;
            r_res.up_count     <= n_up;
            r_res.out_of_range <= r_oor;
            if ((r_cmd == CMD_CLEAR) || r_oor) begin
                r_res.site_value <= 1'b0;
            end else if (r_cmd == CMD_WRITE) begin
                r_res.site_value <= r_wval;
            end else if (do_swap) begin
                r_res.site_value <= r_b;
            end else begin
                r_res.site_value <= r_a;
            end
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

FILE: sv/lattice_gas_exchange_step_core.sv
`default_nettype none

// Toroidal one-bit lattice with exchange moves, site access and move counters.
// Command channel: an item on i_item is taken at a rising edge where start is
// high and busy is low. busy stays high until the result has been shown.
// Result channel: o_result is valid for exactly one cycle while o_done is high;
// the receiver cannot hold it off, so it must take it in that cycle.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at the
// edge; write only while busy is low.
// Steps after the accepting edge: clear and out-of-range items go straight to
// commit and then show o_done. Read, write and move items read a window of
// four rows through the single read port of the row memory, form the neighbor
// sum, multiply, then commit and show o_done. A vertical swap adds a second
// write, of the partner row, through the write port before o_done.
// Reset (synchronous, active low) clears the row valid flags, so the whole
// lattice reads empty at once with no clearing pass; counters return to zero
// and configuration registers to their defaults.

module lattice_gas_exchange_step_core import lgx_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_done,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl  ctl;
    t_stat stat;

    lgx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .busy    (busy),
        .o_done  (o_done)
    );

    lgx_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

FILE: sv/lgx_checker.sv
`default_nettype none

`include "lattice_gas_exchange_step_core_assert.svh"

module lgx_checker import lgx_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_done,
    input wire t_result o_result
);

    // a transfer in makes the block busy
    `LGX_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // one result per item, one cycle long
    `LGX_ASSERT_NEXT(a_done_single, o_done, !o_done)
    `LGX_ASSERT_SAME(a_done_busy, o_done, busy)
    `LGX_ASSERT_NEXT(a_done_idle, o_done, !busy)
    // an out-of-range item reports no swap and an empty site
    `LGX_ASSERT_SAME(a_oor_quiet, o_done && o_result.out_of_range, !o_result.swapped && !o_result.site_value)

endmodule

bind lattice_gas_exchange_step_core lgx_checker u_lgx_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

FILE: verif/lattice_gas_exchange_step_core_test.sv
`default_nettype none

module lattice_gas_exchange_step_core_test;
    import lgx_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int BOUNCE_MOVES  = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_item                 i_item;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lattice_gas_exchange_step_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lattice shadow and its settings
    bit                     occupancy_map [MAX_ROWS][MAX_COLS];
    logic [COUNT_W-1:0]     moves_down       = '0;
    logic [COUNT_W-1:0]     moves_up         = '0;
    logic [SIZE_W-1:0]      rows_cfg         = RST_ROWS;
    logic [SIZE_W-1:0]      cols_cfg         = RST_COLS;
    logic [CFG_DATA_W-1:0]  weights_low_cfg  = RST_CW_LOW;
    logic [CFG_DATA_W-1:0]  weights_high_cfg = RST_CW_HIGH;
    logic [WEIGHT_W-1:0]    weight_top_cfg   = RST_CW_TOP;
    logic [FIELD_CFG_W-1:0] field_cfg        = RST_FIELD;

    t_result expected_results[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      idle_pct       = 0;

    function automatic int wrap_size(logic [SIZE_W-1:0] v, int bound);
        if (v == 0) return 1;
        if (v > bound) return bound;
        return int'(v);
    endfunction

    function automatic int next_index(int x, int n);
        return (x + 1 >= n) ? 0 : x + 1;
    endfunction

    function automatic int prev_index(int x, int n);
        return (x == 0) ? n - 1 : x - 1;
    endfunction

    function automatic int neighbor_count(int r, int c, int nr, int nc);
        return int'(occupancy_map[next_index(r, nr)][c])
             + int'(occupancy_map[prev_index(r, nr)][c])
             + int'(occupancy_map[r][next_index(c, nc)])
             + int'(occupancy_map[r][prev_index(c, nc)]);
    endfunction

    function automatic logic [WEIGHT_W-1:0] coupling_for(int idx);
        if (idx < 4) return weights_low_cfg[16*idx +: 16];
        if (idx < 8) return weights_high_cfg[16*(idx-4) +: 16];
        return weight_top_cfg;
    endfunction

    // applies one command to the shadow lattice and returns what the block should report
    function automatic t_result apply_command(t_item it);
        t_result            res;
        int                 nr, nc, r, c, pr, pc, idx;
        bit                 a, b;
        logic [WEIGHT_W-1:0] fw;
        logic [PROD_W-1:0]  prod;
        logic [PROD_W-1:0]  bar;
        res = '0;
        nr  = wrap_size(rows_cfg, MAX_ROWS);
        nc  = wrap_size(cols_cfg, MAX_COLS);
        r   = int'(it.row);
        c   = int'(it.col);
        if (it.cmd == CMD_CLEAR) begin
            moves_down = '0;
            moves_up   = '0;
        end else if (r >= nr || c >= nc) begin
            res.out_of_range = 1'b1;
        end else if (it.cmd == CMD_WRITE) begin
            occupancy_map[r][c] = it.write_value;
            res.site_value      = it.write_value;
        end else if (it.cmd == CMD_READ) begin
            res.site_value = occupancy_map[r][c];
        end else begin
            pr = r;
            pc = c;
            fw = field_cfg[31:16];
            case (it.direction)
                DIR_DOWN: begin
                    pr = next_index(r, nr);
                    fw = field_cfg[47:32];
                end
                DIR_LEFT:  pc = prev_index(c, nc);
                DIR_UP: begin
                    pr = prev_index(r, nr);
                    fw = field_cfg[15:0];
                end
                DIR_RIGHT: pc = next_index(c, nc);
                default: ;
            endcase
            a = occupancy_map[r][c];
            b = occupancy_map[pr][pc];
            if (a != b) begin
                idx  = (a ? neighbor_count(r, c, nr, nc) : 0)
                     + (b ? neighbor_count(pr, pc, nr, nc) : 0);
                prod = {16'b0, coupling_for(idx)} * {16'b0, fw};
                bar  = {16'b0, it.chance} << CHANCE_SHIFT;
                if (prod >= bar) begin
                    occupancy_map[r][c]   = b;
                    occupancy_map[pr][pc] = a;
                    res.swapped = 1'b1;
                    if (it.direction == DIR_DOWN && moves_down != '1) moves_down++;
                    else if (it.direction == DIR_UP && moves_up != '1) moves_up++;
                end
            end
            res.site_value = occupancy_map[r][c];
        end
        res.down_count = moves_down;
        res.up_count   = moves_up;
        return res;
    endfunction

    function automatic t_item make_item(logic [CMD_W-1:0] cmd, int row, int col,
                                        logic [DIR_W-1:0] dir,
                                        logic [CHANCE_W-1:0] chance, logic wval);
        t_item it;
        it.cmd         = cmd;
        it.row         = ROW_FIELD_W'(row);
        it.col         = COL_FIELD_W'(col);
        it.direction   = dir;
        it.chance      = chance;
        it.write_value = wval;
        return it;
    endfunction

    function automatic t_item random_command();
        t_item       it;
        logic [63:0] raw;
        int          sel, nr, nc;
        nr  = wrap_size(rows_cfg, MAX_ROWS);
        nc  = wrap_size(cols_cfg, MAX_COLS);
        sel = $urandom_range(0, 99);
        raw = {$urandom, $urandom};
        it  = raw[$bits(t_item)-1:0];
        if (sel >= 92) return it;
        if (sel < 50) it.cmd = CMD_MOVE;
        else if (sel < 70) it.cmd = CMD_WRITE;
        else if (sel < 86) it.cmd = CMD_READ;
        else it.cmd = CMD_CLEAR;
        // mostly inside the lattice in use, now and then anywhere
        if ($urandom_range(0, 9) != 0) it.row = ROW_FIELD_W'($urandom_range(0, nr - 1));
        if ($urandom_range(0, 9) != 0) it.col = COL_FIELD_W'($urandom_range(0, nc - 1));
        case ($urandom_range(0, 9))
            0: it.chance = '0;
            1: it.chance = '1;
            default: ;
        endcase
        return it;
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return int'($urandom_range(65, 127));
            2: return 64;
            3: return 1;
            default: return int'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [63:0] random_lanes(int lanes, int max_shift);
        logic [63:0]         w;
        logic [WEIGHT_W-1:0] lane;
        w = '0;
        for (int k = 0; k < lanes; k++) begin
            lane = WEIGHT_W'($urandom);
            w[16*k +: 16] = lane >> $urandom_range(0, max_shift);
        end
        if ($urandom_range(0, 7) == 0) w = '1;
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [COUNT_W-1:0] got, logic [COUNT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %0h", o_result));
            end else begin
                want = expected_results.pop_front();
                check_field("site_value", COUNT_W'(o_result.site_value),
                            COUNT_W'(want.site_value));
                check_field("swapped", COUNT_W'(o_result.swapped),
                            COUNT_W'(want.swapped));
                check_field("down_count",   o_result.down_count,   want.down_count);
                check_field("up_count",     o_result.up_count,     want.up_count);
                check_field("out_of_range", COUNT_W'(o_result.out_of_range),
                            COUNT_W'(want.out_of_range));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic store_expected(t_result res);
        expected_results.insert(expected_results.size(), res);
    endtask

    task automatic sender_pause();
        logic [63:0] junk;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            junk = {$urandom, $urandom};
            start  <= 1'b0;
            i_item <= junk[$bits(t_item)-1:0];
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // start stays high until the transfer, busy is sampled at the edge
    task automatic send_item(t_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        store_expected(apply_command(it));
        sender_pause();
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ROWS:    rows_cfg         = data[SIZE_W-1:0];
            CFG_COLS:    cols_cfg         = data[SIZE_W-1:0];
            CFG_CW_LOW:  weights_low_cfg  = data;
            CFG_CW_HIGH: weights_high_cfg = data;
            CFG_CW_TOP:  weight_top_cfg   = data[WEIGHT_W-1:0];
            CFG_FIELD:   field_cfg        = data[FIELD_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(int rows, int cols,
                                logic [CFG_DATA_W-1:0] low, logic [CFG_DATA_W-1:0] high,
                                logic [CFG_DATA_W-1:0] top, logic [CFG_DATA_W-1:0] field);
        wait_for_results();
        put_register(CFG_ROWS, CFG_DATA_W'(rows));
        put_register(CFG_COLS, CFG_DATA_W'(cols));
        put_register(CFG_CW_LOW, low);
        put_register(CFG_CW_HIGH, high);
        put_register(CFG_CW_TOP, top);
        put_register(CFG_FIELD, field);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_item(make_item(CMD_READ, 0, 0, DIR_DOWN, 16'h0000, 1'b0));
        send_item(make_item(CMD_READ, 63, 63, DIR_UP, 16'hFFFF, 1'b1));
        // both sites empty, nothing to exchange
        send_item(make_item(CMD_MOVE, 5, 5, DIR_DOWN, 16'h0000, 1'b0));
    endtask

    task automatic test_site_access();
        send_item(make_item(CMD_WRITE, 0, 0, DIR_LEFT, 16'h0000, 1'b1));
        send_item(make_item(CMD_WRITE, 63, 63, DIR_RIGHT, 16'hFFFF, 1'b1));
        send_item(make_item(CMD_WRITE, 0, 63, DIR_UP, 16'h5555, 1'b1));
        send_item(make_item(CMD_READ, 63, 63, DIR_DOWN, 16'hAAAA, 1'b0));
        send_item(make_item(CMD_WRITE, 63, 63, DIR_DOWN, 16'h0000, 1'b0));
        send_item(make_item(CMD_READ, 63, 63, DIR_LEFT, 16'h0000, 1'b1));
        send_item(make_item(CMD_READ, 0, 63, DIR_RIGHT, 16'h0000, 1'b0));
    endtask

    task automatic test_exchange_moves();
        // zero field for downward moves, full scale upward
        apply_config(3, 4, '1, '1, '1, CFG_DATA_W'({16'h0000, 16'h1000, 16'hFFFF}));
        send_item(make_item(CMD_MOVE, 0, 0, DIR_UP, 16'hFFFF, 1'b0));
        send_item(make_item(CMD_MOVE, 2, 0, DIR_DOWN, 16'h0001, 1'b0));
        send_item(make_item(CMD_MOVE, 2, 0, DIR_DOWN, 16'h0000, 1'b0));
        send_item(make_item(CMD_MOVE, 0, 0, DIR_LEFT, 16'h8000, 1'b0));
        send_item(make_item(CMD_MOVE, 0, 3, DIR_RIGHT, 16'hFFFF, 1'b1));
        send_item(make_item(CMD_MOVE, 1, 1, DIR_RIGHT, 16'h0000, 1'b0));
        send_item(make_item(CMD_MOVE, 3, 0, DIR_UP, 16'h0000, 1'b0));
        send_item(make_item(CMD_READ, 0, 63, DIR_DOWN, 16'h0000, 1'b0));
        send_item(make_item(CMD_CLEAR, 63, 63, DIR_RIGHT, 16'hFFFF, 1'b1));
    endtask

    task automatic test_tiny_lattice();
        // a zero row count acts as one row, an oversize column count as the maximum
        apply_config(0, 127, 64'h8000_8000_8000_8000, '0, '0,
                     CFG_DATA_W'({16'hFFFF, 16'h1000, 16'h0000}));
        send_item(make_item(CMD_WRITE, 0, 5, DIR_DOWN, 16'h0000, 1'b1));
        send_item(make_item(CMD_MOVE, 0, 5, DIR_DOWN, 16'h0000, 1'b0));
        send_item(make_item(CMD_MOVE, 0, 5, DIR_RIGHT, 16'h0000, 1'b0));
        send_item(make_item(CMD_READ, 0, 6, DIR_UP, 16'h0000, 1'b0));
        send_item(make_item(CMD_WRITE, 1, 0, DIR_LEFT, 16'h0000, 1'b1));
    endtask

    task automatic test_random_traffic(int count, int pct);
        apply_config(pick_size(), pick_size(), random_lanes(4, 3), random_lanes(4, 3),
                     random_lanes(1, 3), random_lanes(3, 4));
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            send_item(random_command());
            if ($urandom_range(0, 63) == 0) wait_for_results();
        end
        idle_pct = 0;
    endtask

    task automatic test_move_counts();
        // two rows, one column: a lone particle bounces down on every move
        apply_config(2, 1, RST_CW_LOW, RST_CW_HIGH, CFG_DATA_W'(RST_CW_TOP),
                     CFG_DATA_W'(RST_FIELD));
        send_item(make_item(CMD_WRITE, 0, 0, DIR_DOWN, 16'h0000, 1'b1));
        send_item(make_item(CMD_WRITE, 1, 0, DIR_DOWN, 16'h0000, 1'b0));
        send_item(make_item(CMD_CLEAR, 0, 0, DIR_DOWN, 16'h0000, 1'b0));
        repeat (BOUNCE_MOVES) send_item(make_item(CMD_MOVE, 0, 0, DIR_DOWN, 16'h0000, 1'b0));
        send_item(make_item(CMD_MOVE, 0, 0, DIR_UP, 16'h0000, 1'b0));
        send_item(make_item(CMD_CLEAR, 0, 0, DIR_DOWN, 16'h0000, 1'b0));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_site_access();
        test_exchange_moves();
        test_tiny_lattice();
        test_random_traffic(180, 0);
        test_random_traffic(180, 71);
        test_random_traffic(170, 0);
        test_random_traffic(170, 13);
        test_move_counts();

        wait_for_results();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
